// ===== design/hc3_pkg.sv =====
`default_nettype none
package hc3_pkg;

  localparam int unsigned Mod    = 26;
  localparam int unsigned Dim    = 3;
  localparam int unsigned NumEnt = Dim * Dim;
  localparam int unsigned EntW   = 5;
  localparam int unsigned KeyW   = NumEnt * EntW;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegKey  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMode = 1'b1;

  // Reciprocal of 26 scaled by 2^16, exact quotient for inputs below 4096
  localparam logic [11:0] Recip26 = 12'd2521;
  // 26 * 26, lifts a signed cofactor into a positive range
  localparam logic [11:0] ModSq   = 12'd676;

  typedef struct packed {
    logic [EntW-1:0] letter_0;
    logic [EntW-1:0] letter_1;
    logic [EntW-1:0] letter_2;
    logic            last_block;
  } in_item_t;

  typedef struct packed {
    logic [EntW-1:0] out_letter_0;
    logic [EntW-1:0] out_letter_1;
    logic [EntW-1:0] out_letter_2;
    logic            out_last;
    logic            key_not_invertible;
  } out_item_t;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_COF,
    DS_COF_MOD,
    DS_DET,
    DS_DINV,
    DS_INV_MUL,
    DS_INV_MOD
  } deriv_step_e;

  // Fold a 5-bit value into 0..25
  function automatic logic [EntW-1:0] red26(input logic [EntW-1:0] x);
    red26 = (x >= EntW'(Mod)) ? EntW'(x - EntW'(Mod)) : x;
  endfunction

  // Remainder modulo 26 of a 12-bit value via reciprocal multiply
  function automatic logic [EntW-1:0] mod26(input logic [11:0] x);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [11:0] rem;
    prod  = x * Recip26;
    quo   = prod[23:16];
    rem   = x - 12'(quo * 12'(Mod));
    mod26 = rem[EntW-1:0];
  endfunction

  // Multiplicative inverse modulo 26, zero where none exists
  function automatic logic [EntW-1:0] inv26(input logic [EntW-1:0] x);
    case (x)
      5'd1:    inv26 = 5'd1;
      5'd3:    inv26 = 5'd9;
      5'd5:    inv26 = 5'd21;
      5'd7:    inv26 = 5'd15;
      5'd9:    inv26 = 5'd3;
      5'd11:   inv26 = 5'd19;
      5'd15:   inv26 = 5'd7;
      5'd17:   inv26 = 5'd23;
      5'd19:   inv26 = 5'd11;
      5'd21:   inv26 = 5'd5;
      5'd23:   inv26 = 5'd17;
      5'd25:   inv26 = 5'd25;
      default: inv26 = 5'd0;
    endcase
  endfunction

  // Cyclic successor of a row or column index
  function automatic int unsigned nxt(input int unsigned i);
    nxt = (i == Dim - 1) ? 0 : i + 1;
  endfunction

endpackage
`default_nettype wire

// ===== design/hill_cipher_3x3_block.sv =====
// Hill cipher, 3x3 key, modulo 26.
// Input channel (in_valid_i/in_ready_o/in_item_i): one block of three letters
// per transfer. Output channel (out_valid_o/out_ready_i/out_item_o): one result
// per input transfer, in order. Encrypt multiplies the row vector by the key,
// decrypt by the inverse key; key_not_invertible flags a key whose determinant
// has no inverse modulo 26 (decrypt then yields zero letters).
// Configuration: cfg_we_i with cfg_index_i 0 writes the key, index 1 the mode.
// A key write starts a derivation of the inverse (cofactors, determinant,
// determinant inverse, scaled adjugate); in_ready_o stays low during the
// derivation.
// Two-stage pipeline: products and sums are registered in the sum stage,
// their remainders mod 26 in the output register, which offers the result.
// Throughput: one block per cycle while no derivation runs and the receiver does not stall.
// Reset clears key, mode, inverse key and flag to zero and empties the pipe.
// When the receiver stalls, the output register holds its result; the sum
// stage still takes one more block, and in_ready_o drops once both are full.
`default_nettype none
module hill_cipher_3x3_block (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hc3_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hc3_pkg::KeyW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hc3_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hc3_pkg::out_item_t         out_item_o
);
  import hc3_pkg::*;

  // Configuration and derived state
  logic [KeyW-1:0] key_q;
  logic            mode_q;
  logic [KeyW-1:0] inv_key_q;
  logic            inv_missing_q;
  deriv_step_e     step_q, step_d;
  logic            key_write;

  // Inverse derivation datapath
  logic [EntW-1:0] key_ent     [NumEnt];
  logic [9:0]      cof_pa      [NumEnt];
  logic [9:0]      cof_pb      [NumEnt];
  logic [10:0]     cof_raw_d   [NumEnt];
  logic [10:0]     cof_raw_q   [NumEnt];
  logic [EntW-1:0] cof_q       [NumEnt];
  logic [10:0]     det_d;
  logic [10:0]     det_q;
  logic [EntW-1:0] det_mod;
  logic [EntW-1:0] dinv_d;
  logic [EntW-1:0] dinv_q;
  logic            dinv_none_q;
  logic [9:0]      inv_prod_q  [NumEnt];

  // Block datapath
  logic [EntW-1:0] mat_ent     [NumEnt];
  logic [11:0]     sum_d       [Dim];
  logic [11:0]     s1_sum_q    [Dim];
  logic            s1_last_q;
  logic            s1_flag_q;
  logic            s1_valid_q;
  logic            out_valid_q;
  out_item_t       out_item_q;
  logic            out_adv;
  logic            s1_adv;
  logic            in_take;

  assign key_write = cfg_we_i && (cfg_index_i == RegKey);

  // ---------------------------------------------------------------------
  // Configuration registers and inverse key
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= '0;
      mode_q        <= 1'b0;
      inv_key_q     <= '0;
      inv_missing_q <= 1'b0;
      step_q        <= DS_IDLE;
    end else begin
      step_q <= step_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKey:  key_q  <= cfg_data_i;
          RegMode: mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // Commit the inverse on the last derivation step
      if (step_q == DS_INV_MOD && !key_write) begin
        for (int i = 0; i < NumEnt; i++) begin
          inv_key_q[EntW*i +: EntW] <= mod26({2'b00, inv_prod_q[i]});
        end
        inv_missing_q <= dinv_none_q;
      end
    end
  end

  // Derivation sequencer: a key write (re)starts it from the cofactors
  always_comb begin
    step_d = step_q;
    case (step_q)
      DS_IDLE:    step_d = DS_IDLE;
      DS_COF:     step_d = DS_COF_MOD;
      DS_COF_MOD: step_d = DS_DET;
      DS_DET:     step_d = DS_DINV;
      DS_DINV:    step_d = DS_INV_MUL;
      DS_INV_MUL: step_d = DS_INV_MOD;
      DS_INV_MOD: step_d = DS_IDLE;
      default:    step_d = DS_IDLE;
    endcase
    if (key_write) begin
      step_d = DS_COF;
    end
  end

  // Reduced key entries, raw cofactors from the cyclic index form, determinant and its inverse
  always_comb begin
    for (int i = 0; i < NumEnt; i++) begin
      key_ent[i] = red26(key_q[EntW*i +: EntW]);
    end
    for (int unsigned r = 0; r < Dim; r++) begin
      for (int unsigned c = 0; c < Dim; c++) begin
        cof_pa[Dim*r+c] = 10'(key_ent[Dim*nxt(r)+nxt(c)] * key_ent[Dim*nxt(nxt(r))+nxt(nxt(c))]);
        cof_pb[Dim*r+c] = 10'(key_ent[Dim*nxt(r)+nxt(nxt(c))] * key_ent[Dim*nxt(nxt(r))+nxt(c)]);
        cof_raw_d[Dim*r+c] = {1'b0, cof_pa[Dim*r+c]} - {1'b0, cof_pb[Dim*r+c]};
      end
    end
    det_d = 11'(key_ent[0] * cof_q[0]) + 11'(key_ent[1] * cof_q[1])
          + 11'(key_ent[2] * cof_q[2]);
    det_mod = mod26({1'b0, det_q});
    dinv_d  = inv26(det_mod);
  end

  // Derivation stages; each loads only in its own step
  always_ff @(posedge clk_i) begin
    if (step_q == DS_COF) begin
      cof_raw_q <= cof_raw_d;
    end
    if (step_q == DS_COF_MOD) begin
      for (int i = 0; i < NumEnt; i++) begin
        // Lift the signed cofactor by 26*26 before the remainder
        cof_q[i] <= mod26({cof_raw_q[i][10], cof_raw_q[i]} + ModSq);
      end
    end
    if (step_q == DS_DET) begin
      det_q <= det_d;
    end
    if (step_q == DS_DINV) begin
      dinv_q      <= dinv_d;
      dinv_none_q <= (dinv_d == '0);
    end
    if (step_q == DS_INV_MUL) begin
      // Inverse (r,c) takes the cofactor at (c,r): the adjugate is transposed
      for (int r = 0; r < Dim; r++) begin
        for (int c = 0; c < Dim; c++) begin
          inv_prod_q[Dim*r+c] <= 10'(cof_q[Dim*c+r] * dinv_q);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Block pipeline
  // ---------------------------------------------------------------------
  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_ready_o = s1_adv && (step_q == DS_IDLE);
  assign in_take    = in_valid_i && in_ready_o;

  // Row vector times the selected matrix; letters 26..31 pass unreduced,
  // the final remainder absorbs them
  always_comb begin
    for (int i = 0; i < NumEnt; i++) begin
      mat_ent[i] = red26(mode_q ? inv_key_q[EntW*i +: EntW] : key_q[EntW*i +: EntW]);
    end
    for (int j = 0; j < Dim; j++) begin
      sum_d[j] = 12'(in_item_i.letter_0 * mat_ent[j])
               + 12'(in_item_i.letter_1 * mat_ent[Dim+j])
               + 12'(in_item_i.letter_2 * mat_ent[2*Dim+j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_take;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sum_q  <= sum_d;
      s1_last_q <= in_item_i.last_block;
      s1_flag_q <= inv_missing_q;
    end
    // Advance the sums into the output register, else hold the result
    if (out_adv && s1_valid_q) begin
      out_item_q.out_letter_0       <= mod26(s1_sum_q[0]);
      out_item_q.out_letter_1       <= mod26(s1_sum_q[1]);
      out_item_q.out_letter_2       <= mod26(s1_sum_q[2]);
      out_item_q.out_last           <= s1_last_q;
      out_item_q.key_not_invertible <= s1_flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ===== tb/hc3_checker.sv =====
`timescale 1ns / 100ps
module hc3_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hc3_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hc3_pkg::KeyW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  hc3_pkg::in_item_t           in_item_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  hc3_pkg::out_item_t          out_item_i,
  output int                          mismatch_o,
  output int                          pending_o
);
  import hc3_pkg::*;

  localparam int Base = int'(Mod);
  localparam int N    = int'(Dim);

  logic [KeyW-1:0] cipher_key;
  logic [KeyW-1:0] inverse_key;
  logic            decrypt_on;
  logic            inv_missing;
  out_item_t       expected_blocks[$];
  out_item_t       oldest;
  int              mismatch_count = 0;
  int              waiting_results = 0;

  assign mismatch_o = mismatch_count;
  assign pending_o  = waiting_results;

  function automatic int wrap26(input int x);
    int m;
    m = x % Base;
    return (m < 0) ? m + Base : m;
  endfunction

  // Entries of a packed matrix, folded into 0..25
  function automatic int key_entry(input logic [KeyW-1:0] m, input int r, input int c);
    return int'(m[EntW*(N*r+c) +: EntW]) % Base;
  endfunction

  // Adjugate times determinant inverse; all zero when none exists
  function automatic void derive_inverse_key(input logic [KeyW-1:0] key,
                                             output logic [KeyW-1:0] inv,
                                             output logic missing);
    int k[3][3];
    int cof[3][3];
    int det;
    int dinv;
    det  = 0;
    dinv = 0;
    inv  = '0;
    for (int r = 0; r < N; r++)
      for (int c = 0; c < N; c++)
        k[r][c] = key_entry(key, r, c);
    for (int r = 0; r < N; r++)
      for (int c = 0; c < N; c++)
        cof[r][c] = k[(r+1)%N][(c+1)%N] * k[(r+2)%N][(c+2)%N]
                  - k[(r+1)%N][(c+2)%N] * k[(r+2)%N][(c+1)%N];
    for (int c = 0; c < N; c++)
      det += k[0][c] * cof[0][c];
    det = wrap26(det);
    for (int d = 1; d < Base; d++)
      if (dinv == 0 && (det * d) % Base == 1) dinv = d;
    missing = (dinv == 0);
    for (int r = 0; r < N; r++)
      for (int c = 0; c < N; c++)
        inv[EntW*(N*r+c) +: EntW] = EntW'(wrap26(wrap26(cof[c][r]) * dinv));
  endfunction

  // Row vector times the active matrix, modulo 26
  function automatic out_item_t hill_transform(input in_item_t blk);
    logic [KeyW-1:0] m;
    int p[3];
    int s[3];
    out_item_t res;
    m    = decrypt_on ? inverse_key : cipher_key;
    p[0] = int'(blk.letter_0);
    p[1] = int'(blk.letter_1);
    p[2] = int'(blk.letter_2);
    for (int j = 0; j < N; j++) begin
      s[j] = 0;
      for (int t = 0; t < N; t++)
        s[j] += p[t] * key_entry(m, t, j);
    end
    res.out_letter_0       = EntW'(wrap26(s[0]));
    res.out_letter_1       = EntW'(wrap26(s[1]));
    res.out_letter_2       = EntW'(wrap26(s[2]));
    res.out_last           = blk.last_block;
    res.key_not_invertible = inv_missing;
    return res;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key  = '0;
      inverse_key = '0;
      decrypt_on  = 1'b0;
      inv_missing = 1'b0;
      expected_blocks.delete();
      waiting_results = 0;
    end else begin
      // compare before queuing, so a result with nothing pending is caught
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          mismatch_count++;
          $display("%0t: result expected none got %h", $time, out_item_i);
        end else begin
          oldest = expected_blocks.pop_front();
          check_field("out_letter_0", oldest.out_letter_0, out_item_i.out_letter_0);
          check_field("out_letter_1", oldest.out_letter_1, out_item_i.out_letter_1);
          check_field("out_letter_2", oldest.out_letter_2, out_item_i.out_letter_2);
          check_field("out_last", oldest.out_last, out_item_i.out_last);
          check_field("key_not_invertible", oldest.key_not_invertible,
                      out_item_i.key_not_invertible);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegKey: begin
            cipher_key = cfg_data_i;
            derive_inverse_key(cipher_key, inverse_key, inv_missing);
          end
          RegMode: begin
            decrypt_on = cfg_data_i[0];
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_blocks.push_back(hill_transform(in_item_i));
      waiting_results = expected_blocks.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import hc3_pkg::*;

  // Receiver hold-off length for the back-pressure stretch, in cycles
  localparam int LongHold     = 60;
  localparam int RandomBlocks = 600;
  localparam int DirectedLen  = 4;

  // Known invertible key: rows (6 24 1) (13 16 10) (20 17 15), det = 25 mod 26
  localparam logic [KeyW-1:0] ClassicKey = {5'd15, 5'd17, 5'd20,
                                            5'd10, 5'd16, 5'd13,
                                            5'd1,  5'd24, 5'd6};

  typedef enum int {StressNone, StressRx, StressTx} stress_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [KeyW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_item_t           out_item_o;

  int mismatches;
  int waiting;
  int blocks_sent;
  bit no_idle;
  bit rx_hold_req;

  hill_cipher_3x3_block DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  hc3_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .mismatch_o  (mismatches),
    .pending_o   (waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Mostly legal letters; every so often the 26..31 range to hit all bits
  function automatic logic [EntW-1:0] random_letter();
    if ($urandom_range(0, 7) == 0) return EntW'($urandom_range(0, 31));
    return EntW'($urandom_range(0, 25));
  endfunction

  function automatic in_item_t random_block();
    in_item_t blk;
    blk.letter_0   = random_letter();
    blk.letter_1   = random_letter();
    blk.letter_2   = random_letter();
    // short messages: roughly one block in five closes one
    blk.last_block = ($urandom_range(0, 4) == 0);
    return blk;
  endfunction

  // Field extremes: all zero, top legal letter, all-ones and other out-of-range letters, alternating bits
  function automatic in_item_t directed_block(input int i);
    case (i)
      0:       return in_item_t'{5'd0,  5'd0,  5'd0,  1'b0};
      1:       return in_item_t'{5'd25, 5'd25, 5'd25, 1'b1};
      2:       return in_item_t'{5'd31, 5'd26, 5'd31, 1'b0};
      default: return in_item_t'{5'b10101, 5'b01010, 5'd1, 1'b1};
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int rx_stall;
    rx_stall    = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_stall    = LongHold;
        rx_hold_req = 1'b0;
      end else if (rx_stall == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
        rx_stall = gap_len();
      end
      if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one block, optionally after a gap; hold it until the transfer
  task automatic send_block(input in_item_t blk);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = gap_len();
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= blk;
    do @(posedge clk_i); while (!in_ready_o);
    blocks_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One setting: drain, write the mode (and the key last, since its
  // derivation keeps the block busy), then stream blocks
  task automatic run_phase(input bit set_key, input logic [KeyW-1:0] key,
                           input logic mode, input int count,
                           input bit directed, input stress_e stress);
    drain_pipe();
    write_reg(RegMode, KeyW'(mode));
    if (set_key) write_reg(RegKey, key);
    for (int i = 0; i < count; i++) begin
      // stall the receiver and keep offering, so the pipe fills and backs up
      if (stress == StressRx && i == 4) rx_hold_req = 1'b1;
      // pause the sender until the pipe is empty, then resume
      if (stress == StressTx && i == count / 2) drain_pipe();
      send_block(directed ? directed_block(i) : random_block());
    end
  endtask

  initial begin : stimulus
    int phase;
    logic [KeyW-1:0] key;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    no_idle     = 1'b0;
    rx_hold_req = 1'b0;
    blocks_sent = 0;
    phase       = 0;
    rst_ni      = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Decrypt before any key write: zero letters, flag clear
    run_phase(1'b0, '0, 1'b1, DirectedLen, 1'b1, StressNone);
    // Invertible key, both directions
    run_phase(1'b1, ClassicKey, 1'b0, DirectedLen, 1'b1, StressNone);
    run_phase(1'b0, ClassicKey, 1'b1, DirectedLen, 1'b1, StressNone);
    // All entries 31 fold to 5: singular key, decrypt gives zeros with flag
    run_phase(1'b1, '1, 1'b1, DirectedLen, 1'b1, StressNone);
    run_phase(1'b0, '1, 1'b0, DirectedLen, 1'b1, StressNone);
    // Zero key: singular, encrypt output all zero
    run_phase(1'b1, '0, 1'b0, DirectedLen, 1'b1, StressNone);

    // Random settings; some phases run back to back with no idling at all
    blocks_sent = 0;
    while (blocks_sent < RandomBlocks) begin
      no_idle = (phase % 5 == 2);
      key = KeyW'({$urandom, $urandom});
      run_phase(phase == 0 || $urandom_range(0, 3) != 0, key, 1'($urandom_range(0, 1)),
                $urandom_range(20, 70), 1'b0,
                (phase == 1) ? StressRx : (phase == 3) ? StressTx : StressNone);
      phase++;
    end
    no_idle = 1'b0;

    drain_pipe();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hc3_pkg.sv
design/hill_cipher_3x3_block.sv
tb/hc3_checker.sv
tb/tb_top.sv
